// ----- src/page_frame_allocator_core_defines.svh -----
// Assertion macros used by the checker file of the page-frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define PFA_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PFA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define PFA_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pfa_pkg.sv -----
`timescale 1ns / 1ps

package pfa_pkg;

  // Fixed field widths of the request, response and configuration port.
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 28;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 17;
  localparam int START_W    = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  // Area bounds are compared one bit wider so that start plus count never wraps.
  localparam int AREA_W     = CNT_W + 1;

  localparam int MAX_FRAMES_DEF     = 65536;
  localparam int FRAME_BYTES_DEF    = 4096;
  localparam int RESERVED_AREAS_DEF = 2;

  localparam logic [CNT_W-1:0] TOTAL_FRAMES_RST = CNT_W'(65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES       = 3'd0,
    CFG_KERNEL_START_FRAME = 3'd1,
    CFG_KERNEL_FRAME_COUNT = 3'd2,
    CFG_RESERVED_A_START   = 3'd3,
    CFG_RESERVED_A_COUNT   = 3'd4,
    CFG_RESERVED_B_START   = 3'd5,
    CFG_RESERVED_B_COUNT   = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_TAIL,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]   total_frames;
    logic [START_W-1:0] kernel_start_frame;
    logic [CNT_W-1:0]   kernel_frame_count;
    logic [START_W-1:0] reserved_a_start;
    logic [CNT_W-1:0]   reserved_a_count;
    logic [START_W-1:0] reserved_b_start;
    logic [CNT_W-1:0]   reserved_b_count;
  } cfg_t;

  // Write strobes of the two frame memories.
  typedef struct packed {
    logic link_we;
    logic use_we;
    logic use_wbit;
  } store_ctrl_t;

  // Width of a count of frames in effect, never wider than the count fields.
  function automatic int nf_width(int max_frames);
    int w;
    w = $clog2(max_frames + 1);
    return (w < CNT_W) ? w : CNT_W;
  endfunction

endpackage

// ----- src/pfa_stream_ifs.sv -----
`timescale 1ns / 1ps

// Request channel: operation kind and the address of a frame to release.
interface pfa_req_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] frame_address;

  modport source (output valid, output kind, output frame_address, input ready);
  modport sink   (input valid, input kind, input frame_address, output ready);
endinterface

// Response channel: one response per request.
interface pfa_rsp_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, output result_address, output status,
                  output used_count, output free_count, input ready);
  modport sink   (input valid, input result_address, input status,
                  input used_count, input free_count, output ready);
endinterface

// ----- src/pfa_cfg_regs.sv -----
`timescale 1ns / 1ps

module pfa_cfg_regs #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  localparam int NFW = pfa_pkg::nf_width(MAX_FRAMES)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pfa_pkg::cfg_t                     cfg,
  output logic [NFW-1:0]                    nf
);
  import pfa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_frames       <= TOTAL_FRAMES_RST;
      cfg.kernel_start_frame <= '0;
      cfg.kernel_frame_count <= '0;
      cfg.reserved_a_start   <= '0;
      cfg.reserved_a_count   <= '0;
      cfg.reserved_b_start   <= '0;
      cfg.reserved_b_count   <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_TOTAL_FRAMES:       cfg.total_frames       <= CNT_W'(cfg_data);
        CFG_KERNEL_START_FRAME: cfg.kernel_start_frame <= START_W'(cfg_data);
        CFG_KERNEL_FRAME_COUNT: cfg.kernel_frame_count <= CNT_W'(cfg_data);
        CFG_RESERVED_A_START:   cfg.reserved_a_start   <= START_W'(cfg_data);
        CFG_RESERVED_A_COUNT:   cfg.reserved_a_count   <= CNT_W'(cfg_data);
        CFG_RESERVED_B_START:   cfg.reserved_b_start   <= START_W'(cfg_data);
        CFG_RESERVED_B_COUNT:   cfg.reserved_b_count   <= CNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Frames in effect: the configured total, clipped to the memory depth.
  assign nf = (int'(cfg.total_frames) < MAX_FRAMES) ? NFW'(cfg.total_frames)
                                                     : NFW'(MAX_FRAMES);

endmodule

// ----- src/pfa_area_check.sv -----
`timescale 1ns / 1ps

module pfa_area_check #(
  parameter int MAX_FRAMES     = pfa_pkg::MAX_FRAMES_DEF,
  parameter int RESERVED_AREAS = pfa_pkg::RESERVED_AREAS_DEF,
  localparam int NFW = pfa_pkg::nf_width(MAX_FRAMES)
) (
  input  pfa_pkg::cfg_t  cfg,
  input  logic [NFW-1:0] frame,
  output logic           reserved
);
  import pfa_pkg::*;

  logic [AREA_W-1:0] f;
  logic in_kernel, in_a, in_b;

  assign f = AREA_W'(frame);

  // All areas are half-open: start is inside, start plus count is not.
  assign in_kernel = (f >= AREA_W'(cfg.kernel_start_frame)) &&
                     (f < AREA_W'(cfg.kernel_start_frame) + AREA_W'(cfg.kernel_frame_count));
  assign in_a = (RESERVED_AREAS >= 1) &&
                (f >= AREA_W'(cfg.reserved_a_start)) &&
                (f < AREA_W'(cfg.reserved_a_start) + AREA_W'(cfg.reserved_a_count));
  assign in_b = (RESERVED_AREAS >= 2) &&
                (f >= AREA_W'(cfg.reserved_b_start)) &&
                (f < AREA_W'(cfg.reserved_b_start) + AREA_W'(cfg.reserved_b_count));

  assign reserved = (frame == '0) || in_kernel || in_a || in_b;

endmodule

// ----- src/pfa_frame_store.sv -----
`timescale 1ns / 1ps

module pfa_frame_store #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  localparam int FW = $clog2(MAX_FRAMES)
) (
  input  logic                 clk,
  input  pfa_pkg::store_ctrl_t ctrl,
  input  logic [FW-1:0]        link_waddr,
  input  logic [FW-1:0]        link_wdata,
  input  logic [FW-1:0]        link_raddr,
  output logic [FW-1:0]        link_rdata,
  input  logic [FW-1:0]        use_waddr,
  input  logic [FW-1:0]        use_raddr,
  output logic                 use_rdata
);
  import pfa_pkg::*;

  // Next-pointer of every frame and its used bit; neither is cleared by reset.
  logic [FW-1:0] link_mem [MAX_FRAMES];
  logic          use_mem  [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (ctrl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.use_we) begin
      use_mem[use_waddr] <= ctrl.use_wbit;
    end
    use_rdata <= use_mem[use_raddr];
  end

endmodule

// ----- src/page_frame_allocator_core.sv -----
// Page-frame allocator core. Physical memory is split into frames of FRAME_BYTES bytes;
// free frames form a singly linked list kept in a next-pointer memory, and a second
// memory holds a used bit per frame. An init request rebuilds both from the
// configuration registers: frame 0, the kernel area and up to two reserved areas
// (all half-open, start included, start plus count excluded) are marked used, and
// the remaining frames are chained in ascending order. An alloc request pops the head
// of the list and returns its byte address, or status empty with address 0. A free
// request checks alignment, range and the used bit, then pushes the frame back on the
// head; a misaligned address, frame 0, a frame beyond the frames in effect or a frame
// that is not in use gives status invalid and changes nothing. Kind 3 is a no-op.
// Every request returns exactly one response carrying the used and free counts.
// Alloc, free and no-op requests pass from the accept cycle to an execute cycle,
// since the link and used-bit memories have registered reads.
// Init accepts the request, then walks the frames, one frame per cycle through the
// single write port of the used-bit memory, then sees that the walk is done and
// terminates the list; no request is accepted meanwhile. Free before any init, or
// of a frame that the last init did not cover, reads a used bit that was never
// written and is not allowed. FRAME_BYTES must be a power of two. The user must
// write configuration only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module page_frame_allocator_core #(
  parameter int MAX_FRAMES     = pfa_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_BYTES    = pfa_pkg::FRAME_BYTES_DEF,
  parameter int RESERVED_AREAS = pfa_pkg::RESERVED_AREAS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  pfa_req_if.sink                        req,
  pfa_rsp_if.source                      rsp,
  input  logic                           cfg_wen,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfa_pkg::*;

  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int NFW   = nf_width(MAX_FRAMES);
  localparam int OFF_W = $clog2(FRAME_BYTES);
  localparam int FN_W  = ADDR_W - OFF_W;
  localparam int CMP_W = (FN_W > NFW) ? FN_W : NFW;
  localparam int PA_W  = FW + OFF_W;

  // Configuration and the frame count it puts in effect.
  cfg_t           cfg;
  logic [NFW-1:0] nf;

  pfa_cfg_regs #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .nf        (nf)
  );

  // Control state.
  state_t           state, state_next;
  logic [FW-1:0]    head, head_next;
  logic [CNT_W-1:0] free_total, free_total_next;
  logic [CNT_W-1:0] used_total, used_total_next;
  logic             have_prev, have_prev_next;
  logic             out_valid, out_valid_next;

  // Per-request working registers.
  kind_t            kind_q, kind_q_next;
  logic             free_ok, free_ok_next;
  logic [FW-1:0]    free_idx, free_idx_next;
  logic [NFW-1:0]   cnt, cnt_next;
  logic [FW-1:0]    prev, prev_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  status_t          pend_status, pend_status_next;

  // Response register.
  logic [ADDR_W-1:0] out_addr, out_addr_next;
  status_t           out_status, out_status_next;
  logic [CNT_W-1:0]  out_used, out_used_next;
  logic [CNT_W-1:0]  out_free, out_free_next;

  // Memory port signals.
  store_ctrl_t   ctrl;
  logic [FW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic [FW-1:0] use_waddr, use_raddr;
  logic          use_rdata;

  // The init walk asks whether the frame under the counter is reserved.
  logic init_reserved;

  pfa_area_check #(
    .MAX_FRAMES    (MAX_FRAMES),
    .RESERVED_AREAS(RESERVED_AREAS)
  ) u_area_check (
    .cfg      (cfg),
    .frame    (cnt),
    .reserved (init_reserved)
  );

  pfa_frame_store #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_frame_store (
    .clk        (clk),
    .ctrl       (ctrl),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .use_waddr  (use_waddr),
    .use_raddr  (use_raddr),
    .use_rdata  (use_rdata)
  );

  // Decode of the frame named by a free request. The range test runs in the
  // accept cycle so that the execute cycle only has to look at the used bit.
  logic [FN_W-1:0] req_fn;
  logic [FW-1:0]   req_idx;
  logic            req_free_ok;

  assign req_fn      = req.frame_address[ADDR_W-1:OFF_W];
  assign req_idx     = FW'(req_fn);
  assign req_free_ok = (req.frame_address[OFF_W-1:0] == '0) && (req_fn != '0) &&
                       (CMP_W'(req_fn) < CMP_W'(nf));

  // Byte address of the current list head, cut to the address width.
  logic [PA_W-1:0] head_pa;
  assign head_pa = {head, {OFF_W{1'b0}}};

  // A response slot is free when the register is empty or is drained this cycle.
  logic slot_free;
  assign slot_free = !out_valid || rsp.ready;

  logic              finish;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  always_comb begin
    state_next       = state;
    head_next        = head;
    free_total_next  = free_total;
    used_total_next  = used_total;
    have_prev_next   = have_prev;
    kind_q_next      = kind_q;
    free_ok_next     = free_ok;
    free_idx_next    = free_idx;
    cnt_next         = cnt;
    prev_next        = prev;
    pend_addr_next   = pend_addr;
    pend_status_next = pend_status;
    out_valid_next   = out_valid && !rsp.ready;
    out_addr_next    = out_addr;
    out_status_next  = out_status;
    out_used_next    = out_used;
    out_free_next    = out_free;

    ctrl       = '0;
    link_waddr = '0;
    link_wdata = '0;
    use_waddr  = '0;
    // Reads are issued in the accept cycle; data is used in the execute cycle.
    link_raddr = head;
    use_raddr  = req_idx;

    req.ready  = 1'b0;
    finish     = 1'b0;
    res_addr   = '0;
    res_status = STATUS_OK;

    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          kind_q_next   = kind_t'(req.kind);
          free_ok_next  = req_free_ok;
          free_idx_next = req_idx;
          if (kind_t'(req.kind) == KIND_INIT) begin
            cnt_next        = '0;
            have_prev_next  = 1'b0;
            head_next       = '0;
            free_total_next = '0;
            used_total_next = '0;
            state_next      = S_INIT;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        finish = 1'b1;
        case (kind_q)
          KIND_ALLOC: begin
            if (free_total == '0) begin
              res_status = STATUS_EMPTY;
            end else begin
              // Pop: the link read of the old head becomes the new head.
              head_next       = link_rdata;
              ctrl.use_we     = 1'b1;
              ctrl.use_wbit   = 1'b1;
              use_waddr       = head;
              free_total_next = free_total - CNT_W'(1);
              used_total_next = used_total + CNT_W'(1);
              res_addr        = ADDR_W'(head_pa);
            end
          end
          KIND_FREE: begin
            if (free_ok && use_rdata) begin
              // Push onto the head of the list.
              ctrl.use_we     = 1'b1;
              ctrl.use_wbit   = 1'b0;
              use_waddr       = free_idx;
              ctrl.link_we    = 1'b1;
              link_waddr      = free_idx;
              link_wdata      = head;
              head_next       = free_idx;
              free_total_next = free_total + CNT_W'(1);
              if (used_total != '0) begin
                used_total_next = used_total - CNT_W'(1);
              end
            end else begin
              res_status = STATUS_INVALID;
            end
          end
          default: ;
        endcase
      end

      S_INIT: begin
        if (CNT_W'(cnt) < CNT_W'(nf)) begin
          ctrl.use_we   = 1'b1;
          ctrl.use_wbit = init_reserved;
          use_waddr     = FW'(cnt);
          if (init_reserved) begin
            used_total_next = used_total + CNT_W'(1);
          end else begin
            // Chain the previous free frame to this one, or start the list here.
            if (have_prev) begin
              ctrl.link_we = 1'b1;
              link_waddr   = prev;
              link_wdata   = FW'(cnt);
            end else begin
              head_next = FW'(cnt);
            end
            prev_next       = FW'(cnt);
            have_prev_next  = 1'b1;
            free_total_next = free_total + CNT_W'(1);
          end
          cnt_next = cnt + NFW'(1);
        end else begin
          state_next = S_TAIL;
        end
      end

      S_TAIL: begin
        // Terminate the list at its last frame.
        finish = 1'b1;
        if (have_prev) begin
          ctrl.link_we = 1'b1;
          link_waddr   = prev;
          link_wdata   = '0;
        end
      end

      S_HOLD: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_addr_next   = pend_addr;
          out_status_next = pend_status;
          out_used_next   = used_total;
          out_free_next   = free_total;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A finished request goes straight to the response register when it is free,
    // otherwise it waits in the pending register.
    if (finish) begin
      pend_addr_next   = res_addr;
      pend_status_next = res_status;
      if (slot_free) begin
        out_valid_next  = 1'b1;
        out_addr_next   = res_addr;
        out_status_next = res_status;
        out_used_next   = used_total_next;
        out_free_next   = free_total_next;
        state_next      = S_IDLE;
      end else begin
        state_next = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      free_total <= '0;
      used_total <= '0;
      have_prev  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= free_total_next;
      used_total <= used_total_next;
      have_prev  <= have_prev_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q      <= kind_q_next;
    free_ok     <= free_ok_next;
    free_idx    <= free_idx_next;
    cnt         <= cnt_next;
    prev        <= prev_next;
    pend_addr   <= pend_addr_next;
    pend_status <= pend_status_next;
    out_addr    <= out_addr_next;
    out_status  <= out_status_next;
    out_used    <= out_used_next;
    out_free    <= out_free_next;
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_address = out_addr;
  assign rsp.status         = out_status;
  assign rsp.used_count     = out_used;
  assign rsp.free_count     = out_free;

endmodule

// ----- src/pfa_checker.sv -----
`timescale 1ns / 1ps

module pfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pfa_pkg::ADDR_W-1:0]    rsp_result_address,
  input logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
  input logic [pfa_pkg::CNT_W-1:0]     rsp_used_count,
  input logic [pfa_pkg::CNT_W-1:0]     rsp_free_count
);
  import pfa_pkg::*;

  `include "page_frame_allocator_core_defines.svh"

  // No response may be pending right after reset.
  `PFA_ASSERT_NEXT_ALWAYS(a_rsp_idle_after_rst, clk, rst, !rsp_valid, "response valid after reset")

  // A stalled response keeps its contents.
  `PFA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_address) && $stable(rsp_status) && $stable(rsp_used_count) && $stable(rsp_free_count), "stalled response changed")

  // The engine works on one request at a time.
  `PFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "request taken while busy")

  // Only a successful alloc carries an address.
  `PFA_ASSERT_IMPLY(a_addr_only_ok, clk, rst, rsp_valid && (rsp_result_address != '0), rsp_status == STATUS_OK, "address with failing status")

  // An empty answer means the free list really is empty.
  `PFA_ASSERT_IMPLY(a_empty_consistent, clk, rst, rsp_valid && (rsp_status == STATUS_EMPTY), (rsp_free_count == '0) && (rsp_result_address == '0), "empty status with free frames")

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_result_address (rsp.result_address),
  .rsp_status         (rsp.status),
  .rsp_used_count     (rsp.used_count),
  .rsp_free_count     (rsp.free_count)
);
